[design/pqkr_pkg.sv]
// ----------------------------------------------------------------------------
// pqkr_pkg
// Shared types and constants for the process queue with keyed removal.
// ----------------------------------------------------------------------------
package pqkr_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned PidW              = 16;
  localparam int unsigned DescW             = 32;
  localparam int unsigned OccW              = 5;

  typedef enum logic [1:0] {
    OpEnqueue = 2'd0,
    OpDequeue = 2'd1,
    OpRemove  = 2'd2,
    OpClear   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFull     = 2'd1,
    StatusEmpty    = 2'd2,
    StatusNotFound = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [PidW-1:0]   entry_pid;
    logic [DescW-1:0]  entry_descriptor;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [PidW-1:0]   out_pid;
    logic [DescW-1:0]  out_descriptor;
    logic [OccW-1:0]   occupancy;
    logic              empty_flag;
    logic              full_flag;
  } rsp_t;

  // one stored queue slot
  typedef struct packed {
    logic [PidW-1:0]   pid;
    logic [DescW-1:0]  descriptor;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    load_req;
    logic    enq;
    logic    clear;
    logic    search_init;
    logic    search_step;
    logic    capture;
    logic    shift_step;
    logic    shrink;
    logic    emit;
    logic    use_entry;
    status_e status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic at_end;
  } sts_t;

endpackage

[design/pqkr_ram.sv]
// ----------------------------------------------------------------------------
// pqkr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pqkr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/pqkr_datapath.sv]
// ----------------------------------------------------------------------------
// pqkr_datapath
// Slot store, entry count, walk pointer and result register of the queue.
// ----------------------------------------------------------------------------
module pqkr_datapath #(
  parameter int unsigned QueueDepth = pqkr_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pqkr_pkg::req_t req_i,
  input  pqkr_pkg::cmd_t cmd_i,
  output pqkr_pkg::sts_t sts_o,
  output logic           result_valid_o,
  output pqkr_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned EntW = $bits(pqkr_pkg::entry_t);

  logic [CntW-1:0]                 count_q, count_d;
  logic [CntW-1:0]                 ptr_q, ptr_d;
  logic [CntW-1:0]                 ptr_m1;
  logic                            rv_q, rv_d;
  logic                            valid_q;
  pqkr_pkg::opcode_e               req_op_q, req_op_d;
  logic [pqkr_pkg::PidW-1:0]       req_pid_q, req_pid_d;
  pqkr_pkg::entry_t                ent_q, ent_d;
  pqkr_pkg::rsp_t                  rsp_q, rsp_d;

  logic                            ram_we;
  logic [IdxW-1:0]                 ram_waddr;
  logic [IdxW-1:0]                 ram_raddr;
  pqkr_pkg::entry_t                ram_wdata;
  pqkr_pkg::entry_t                ram_rdata;
  logic [EntW-1:0]                 ram_rdata_raw;

  pqkr_ram #(
    .Width (EntW),
    .Depth (QueueDepth)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = pqkr_pkg::entry_t'(ram_rdata_raw);
  assign ptr_m1    = ptr_q - CntW'(1);

  assign sts_o.full   = (count_q == CntW'(QueueDepth));
  assign sts_o.empty  = (count_q == '0);
  assign sts_o.at_end = (ptr_q >= count_q);
  // read data holds the slot just behind the pointer
  assign sts_o.match  = rv_q && ((req_op_q == pqkr_pkg::OpDequeue) ||
                                 (ram_rdata.pid == req_pid_q));

  always_comb begin
    count_d   = count_q;
    ptr_d     = ptr_q;
    rv_d      = rv_q;
    req_op_d  = req_op_q;
    req_pid_d = req_pid_q;
    ent_d     = ent_q;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[IdxW-1:0];
    ram_raddr = ptr_q[IdxW-1:0];
    ram_wdata = '{pid: req_i.entry_pid, descriptor: req_i.entry_descriptor};

    if (cmd_i.load_req) begin
      req_op_d  = req_i.opcode;
      req_pid_d = req_i.entry_pid;
    end
    if (cmd_i.enq) begin
      ram_we  = 1'b1;
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.clear) begin
      count_d = '0;
    end
    if (cmd_i.search_init) begin
      ptr_d = '0;
      rv_d  = 1'b0;
    end
    if (cmd_i.search_step) begin
      ptr_d = ptr_q + CntW'(1);
      rv_d  = 1'b1;
    end
    if (cmd_i.capture) begin
      ent_d = ram_rdata;
    end
    // close the gap: slot ptr moves down to ptr - 1, next slot read ahead
    if (cmd_i.shift_step) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_m1[IdxW-1:0];
      ram_wdata = ram_rdata;
      ptr_d     = ptr_q + CntW'(1);
      ram_raddr = ptr_d[IdxW-1:0];
    end
    if (cmd_i.shrink) begin
      count_d = count_q - CntW'(1);
    end
    if (cmd_i.emit) begin
      rsp_d.status         = cmd_i.status;
      rsp_d.out_pid        = cmd_i.use_entry ? ent_q.pid : '0;
      rsp_d.out_descriptor = cmd_i.use_entry ? ent_q.descriptor : '0;
      rsp_d.occupancy      = pqkr_pkg::OccW'(count_d);
      rsp_d.empty_flag     = (count_d == '0);
      rsp_d.full_flag      = (count_d == CntW'(QueueDepth));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      rv_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      rv_q    <= rv_d;
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    req_op_q  <= req_op_d;
    req_pid_q <= req_pid_d;
    ent_q     <= ent_d;
    rsp_q     <= rsp_d;
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

[design/pqkr_ctrl.sv]
// ----------------------------------------------------------------------------
// pqkr_ctrl
// Sequencer for request acceptance, search from the head and slot shifting.
// ----------------------------------------------------------------------------
module pqkr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  pqkr_pkg::opcode_e opcode_i,
  input  pqkr_pkg::sts_t    sts_i,
  output logic              busy,
  output pqkr_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StSearch = 3'b010,
    StShift  = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{status: pqkr_pkg::StatusOk, default: 1'b0};

    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load_req = 1'b1;
          unique case (opcode_i)
            pqkr_pkg::OpEnqueue: begin
              cmd_o.emit = 1'b1;
              if (sts_i.full) begin
                cmd_o.status = pqkr_pkg::StatusFull;
              end else begin
                cmd_o.enq = 1'b1;
              end
            end
            pqkr_pkg::OpClear: begin
              cmd_o.clear = 1'b1;
              cmd_o.emit  = 1'b1;
            end
            pqkr_pkg::OpDequeue, pqkr_pkg::OpRemove: begin
              if (sts_i.empty) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = (opcode_i == pqkr_pkg::OpDequeue) ?
                               pqkr_pkg::StatusEmpty : pqkr_pkg::StatusNotFound;
              end else begin
                cmd_o.search_init = 1'b1;
                state_d           = StSearch;
              end
            end
          endcase
        end
      end
      StSearch: begin
        priority if (sts_i.match) begin
          cmd_o.capture = 1'b1;
          state_d       = StShift;
        end else if (sts_i.at_end) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = pqkr_pkg::StatusNotFound;
          state_d      = StIdle;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      StShift: begin
        if (!sts_i.at_end) begin
          cmd_o.shift_step = 1'b1;
        end else begin
          cmd_o.shrink    = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.use_entry = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/process_queue_with_keyed_removal.sv]
// ----------------------------------------------------------------------------
// process_queue_with_keyed_removal
// Bounded ordered queue of (pid, descriptor) entries with removal by pid.
// ----------------------------------------------------------------------------
// A request on req_i is taken at a rising edge with start high and busy low.
// Opcodes: enqueue at the tail, dequeue from the head, remove the first entry
// from the head whose pid matches (order of the rest kept), clear.
// Every request gives exactly one result on rsp_o, shown for one cycle with
// result_valid_o high; the receiver cannot stall, so it must take it then.
// Latency: enqueue, clear and refused requests give their result on the
// cycle after acceptance and busy stays low, so one request per cycle.
// Dequeue and remove walk the slot RAM one slot a cycle: a search over the
// entries up to the match, then a shift of every later entry one slot
// towards the head, limited by the single RAM write port. busy stays high
// through the search and the shift.
// Reset empties the queue at once; the slot RAM is not cleared, as only
// slots below the entry count are ever used.
// ----------------------------------------------------------------------------
module process_queue_with_keyed_removal #(
  parameter int unsigned QueueDepth = pqkr_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pqkr_pkg::req_t req_i,
  output logic           result_valid_o,
  output pqkr_pkg::rsp_t rsp_o
);

  pqkr_pkg::cmd_t cmd;
  pqkr_pkg::sts_t sts;

  pqkr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (req_i.opcode),
    .sts_i    (sts),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  pqkr_datapath #(
    .QueueDepth (QueueDepth)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

endmodule

[design/pqkr_checker.sv]
// ----------------------------------------------------------------------------
// pqkr_checker
// Port level checks on request and result behaviour of the queue.
// ----------------------------------------------------------------------------
module pqkr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input pqkr_pkg::req_t req_i,
  input logic           result_valid_o,
  input pqkr_pkg::rsp_t rsp_o
);

  logic quick_req;
  assign quick_req = start && !busy &&
                     ((req_i.opcode == pqkr_pkg::OpEnqueue) ||
                      (req_i.opcode == pqkr_pkg::OpClear));

  // enqueue and clear answer on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    quick_req |=> result_valid_o)
    else $error("enqueue or clear result missing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.opcode == pqkr_pkg::OpClear) |=>
      (rsp_o.status == pqkr_pkg::StatusOk) && (rsp_o.occupancy == '0) &&
      rsp_o.empty_flag && !rsp_o.full_flag)
    else $error("clear did not empty the queue");

  // nothing taken out means no entry reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status != pqkr_pkg::StatusOk)) |->
      (rsp_o.out_pid == '0) && (rsp_o.out_descriptor == '0))
    else $error("failed request reports an entry");

  // a result closes the request, so the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("busy while showing a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(rsp_o.empty_flag && rsp_o.full_flag))
    else $error("queue both empty and full");

endmodule

bind process_queue_with_keyed_removal pqkr_checker u_pqkr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_i          (req_i),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the process queue with keyed removal.
// Requests are driven in random bursts on the start/busy handshake. A shadow
// queue predicts every response, and each strobed result is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned QueueDepth = pqkr_pkg::QueueDepthDefault;
  localparam int unsigned SettleCycles = QueueDepth + 4;
  localparam int unsigned StallLimit = 1000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  pqkr_pkg::req_t req_i;
  logic result_valid_o;
  pqkr_pkg::rsp_t rsp_o;

  pqkr_pkg::entry_t shadow_queue[$];
  pqkr_pkg::rsp_t predicted_rsps[$];
  logic [pqkr_pkg::PidW-1:0] pid_base;
  int unsigned error_count;
  int unsigned quiet_cycles;

  process_queue_with_keyed_removal #(
    .QueueDepth(QueueDepth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // applies one request to the shadow queue and returns the response it gives
  function automatic pqkr_pkg::rsp_t predict_response(input pqkr_pkg::req_t r);
    pqkr_pkg::rsp_t p;
    pqkr_pkg::entry_t e;
    int hit;
    p = '0;
    p.status = pqkr_pkg::StatusOk;
    case (r.opcode)
      pqkr_pkg::OpEnqueue: begin
        if (shadow_queue.size() >= QueueDepth) begin
          p.status = pqkr_pkg::StatusFull;
        end else begin
          e.pid = r.entry_pid;
          e.descriptor = r.entry_descriptor;
          shadow_queue.push_back(e);
        end
      end
      pqkr_pkg::OpDequeue: begin
        if (shadow_queue.size() == 0) begin
          p.status = pqkr_pkg::StatusEmpty;
        end else begin
          e = shadow_queue.pop_front();
          p.out_pid = e.pid;
          p.out_descriptor = e.descriptor;
        end
      end
      pqkr_pkg::OpRemove: begin
        hit = -1;
        for (int k = 0; k < shadow_queue.size(); k++) begin
          if (hit < 0 && shadow_queue[k].pid == r.entry_pid) hit = k;
        end
        if (hit < 0) begin
          p.status = pqkr_pkg::StatusNotFound;
        end else begin
          p.out_pid = shadow_queue[hit].pid;
          p.out_descriptor = shadow_queue[hit].descriptor;
          shadow_queue.delete(hit);
        end
      end
      default: begin
        shadow_queue.delete();
      end
    endcase
    p.occupancy = pqkr_pkg::OccW'(shadow_queue.size());
    p.empty_flag = (shadow_queue.size() == 0);
    p.full_flag = (shadow_queue.size() >= QueueDepth);
    return p;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] expv,
                                 input logic [31:0] actv);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expv, actv);
    error_count++;
  endtask

  // one request, held until the handshake takes it
  task automatic send_request(input pqkr_pkg::opcode_e op,
                              input logic [pqkr_pkg::PidW-1:0] pid,
                              input logic [pqkr_pkg::DescW-1:0] desc);
    pqkr_pkg::req_t r;
    r.opcode = op;
    r.entry_pid = pid;
    r.entry_descriptor = desc;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted_rsps.push_back(predict_response(r));
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // hold off until every outstanding response has been seen
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (predicted_rsps.size() != 0) @(posedge clk_i);
  endtask

  // mostly ids from a small cluster so that removals find matches
  function automatic logic [pqkr_pkg::PidW-1:0] pick_pid();
    if ($urandom_range(0, 7) == 0) return pqkr_pkg::PidW'($urandom_range(0, 65535));
    return pid_base ^ pqkr_pkg::PidW'($urandom_range(0, 7));
  endfunction

  function automatic logic [pqkr_pkg::PidW-1:0] pick_remove_pid();
    if (shadow_queue.size() != 0 && $urandom_range(0, 9) < 6)
      return shadow_queue[$urandom_range(0, shadow_queue.size() - 1)].pid;
    return pick_pid();
  endfunction

  task automatic send_random_request(input int unsigned enq_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) begin
      send_request(pqkr_pkg::OpEnqueue, pick_pid(), $urandom);
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) send_request(pqkr_pkg::OpClear, pick_pid(), $urandom);
      else if (roll < 50) send_request(pqkr_pkg::OpRemove, pick_remove_pid(), $urandom);
      else send_request(pqkr_pkg::OpDequeue, pick_pid(), $urandom);
    end
  endtask

  task automatic test_directed_corners();
    send_request(pqkr_pkg::OpDequeue, '0, '0);
    send_request(pqkr_pkg::OpRemove, '0, '0);
    send_request(pqkr_pkg::OpClear, '1, '1);
    // fill to the brim with repeated ids and extreme values at both ends
    send_request(pqkr_pkg::OpEnqueue, '0, '0);
    for (int k = 1; k < QueueDepth - 1; k++)
      send_request(pqkr_pkg::OpEnqueue, pqkr_pkg::PidW'(k % 4), $urandom);
    send_request(pqkr_pkg::OpEnqueue, '1, '1);
    send_request(pqkr_pkg::OpEnqueue, 16'h1234, 32'h5555_aaaa);
    // duplicate ids: only the one nearest the head goes
    send_request(pqkr_pkg::OpRemove, 16'd2, '0);
    send_request(pqkr_pkg::OpRemove, 16'h1234, '0);
    send_request(pqkr_pkg::OpRemove, '1, '0);
    send_request(pqkr_pkg::OpDequeue, '1, '1);
    send_request(pqkr_pkg::OpClear, '0, '0);
    drain_results();
  endtask

  task automatic test_fill_and_drain();
    pid_base = pqkr_pkg::PidW'($urandom_range(0, 65535));
    repeat (6) begin
      for (int k = 0; k < QueueDepth + 2; k++)
        send_request(pqkr_pkg::OpEnqueue, pick_pid(), $urandom);
      while (shadow_queue.size() != 0) begin
        if ($urandom_range(0, 1) == 0)
          send_request(pqkr_pkg::OpDequeue, pick_pid(), $urandom);
        else
          send_request(pqkr_pkg::OpRemove, pick_remove_pid(), $urandom);
      end
      send_request(pqkr_pkg::OpDequeue, pick_pid(), $urandom);
      send_request(pqkr_pkg::OpRemove, pick_pid(), $urandom);
      drain_results();
    end
  endtask

  task automatic test_keyed_removal();
    int unsigned fill;
    pid_base = pqkr_pkg::PidW'($urandom_range(0, 65535));
    repeat (20) begin
      fill = $urandom_range(1, QueueDepth);
      repeat (fill) begin
        send_request(pqkr_pkg::OpEnqueue,
                     pid_base ^ pqkr_pkg::PidW'($urandom_range(0, 3)), $urandom);
        if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 6));
      end
      repeat ($urandom_range(2, 12)) begin
        send_request(pqkr_pkg::OpRemove,
                     pid_base ^ pqkr_pkg::PidW'($urandom_range(0, 4)), $urandom);
        if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 20));
      end
      send_request(pqkr_pkg::OpClear, pick_pid(), $urandom);
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned burst;
    int unsigned enq_pct;
    sent = 0;
    while (sent < 1350) begin
      if ($urandom_range(0, 9) == 0) pid_base = pqkr_pkg::PidW'($urandom_range(0, 65535));
      case ($urandom_range(0, 2))
        0: enq_pct = 20;
        1: enq_pct = 50;
        default: enq_pct = 80;
      endcase
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_random_request(enq_pct);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) drain_results();
      else if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 20));
    end
    drain_results();
  endtask

  always @(posedge clk_i) begin : check_responses
    pqkr_pkg::rsp_t expected;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (predicted_rsps.size() == 0) begin
        $display("%0t: response with none outstanding, got %0h", $time, rsp_o);
        error_count++;
      end else begin
        expected = predicted_rsps.pop_front();
        if (expected.status !== rsp_o.status)
          report_mismatch("status", 32'(expected.status), 32'(rsp_o.status));
        if (expected.out_pid !== rsp_o.out_pid)
          report_mismatch("out_pid", 32'(expected.out_pid), 32'(rsp_o.out_pid));
        if (expected.out_descriptor !== rsp_o.out_descriptor)
          report_mismatch("out_descriptor", expected.out_descriptor, rsp_o.out_descriptor);
        if (expected.occupancy !== rsp_o.occupancy)
          report_mismatch("occupancy", 32'(expected.occupancy), 32'(rsp_o.occupancy));
        if (expected.empty_flag !== rsp_o.empty_flag)
          report_mismatch("empty_flag", 32'(expected.empty_flag), 32'(rsp_o.empty_flag));
        if (expected.full_flag !== rsp_o.full_flag)
          report_mismatch("full_flag", 32'(expected.full_flag), 32'(rsp_o.full_flag));
      end
    end
  end

  // no request taken and no response seen for too long means a hang
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || result_valid_o === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    quiet_cycles = 0;
    pid_base = '0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_fill_and_drain();
    test_keyed_removal();
    test_random_traffic();

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0 && predicted_rsps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/pqkr_pkg.sv
design/pqkr_ram.sv
design/pqkr_datapath.sv
design/pqkr_ctrl.sv
design/process_queue_with_keyed_removal.sv
design/pqkr_checker.sv
test/testbench.sv
